// ===== rtl/mtec_pkg.sv =====
// ----------------------------------------------------------------------------
// mtec_pkg
// Types and constants shared by the mode timer / event counter.
// ----------------------------------------------------------------------------
package mtec_pkg;

  localparam int unsigned PRESCALE    = 32;
  localparam int unsigned PrescaleW   = (PRESCALE > 2) ? $clog2(PRESCALE) : 1;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_STOP     = 4'd1,
    OP_DEC      = 4'd2,
    OP_PULSE    = 4'd3,
    OP_EVENT    = 4'd4,
    OP_LOAD     = 4'd5,
    OP_TIMER    = 4'd6,
    OP_READ     = 4'd7,
    OP_TOG_EN   = 4'd8,
    OP_BRANCH   = 4'd9
  } op_e;

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_PULSE = 2'd1,
    MODE_EVENT = 2'd2,
    MODE_TIMER = 2'd3
  } mode_e;

  typedef struct packed {
    logic [7:0]           counter;
    logic [7:0]           reload;
    mode_e                mode;
    logic                 stopped;
    logic [PrescaleW-1:0] prescale;
    logic                 toggle_en;
    logic                 irq;
    logic [3:0]           prev_flags;
    logic                 watched;
  } state_t;

  typedef struct packed {
    logic       flag_choice;
    logic [3:0] ext_flags;
    logic [7:0] load_data;
    logic [3:0] op;
  } item_t;

  typedef struct packed {
    logic       branch_taken;
    logic       q_toggle;
    logic       counter_interrupt;
    logic [7:0] count_value;
  } result_t;

endpackage

// ===== rtl/mtec_step.sv =====
// ----------------------------------------------------------------------------
// mtec_step
// Next-state and result logic for one transfer of the counter/timer.
// ----------------------------------------------------------------------------
module mtec_step (
  input  mtec_pkg::state_t  state_i,
  input  mtec_pkg::item_t   item_i,
  input  logic              variant_later_i,
  output mtec_pkg::state_t  state_o,
  output mtec_pkg::result_t result_o
);

  logic                               cycle_en;
  logic                               dec_req;
  logic                               dec_en;
  logic                               cur_flag;
  logic                               prev_flag;
  logic [mtec_pkg::PrescaleW:0]       pre_nxt;
  logic [7:0]                         cnt_dec;
  logic                               qt;
  logic                               taken;
  mtec_pkg::state_t                   s;

  assign cur_flag  = item_i.ext_flags[state_i.watched];
  assign prev_flag = state_i.prev_flags[state_i.watched];
  assign pre_nxt   = {1'b0, state_i.prescale} + 1'b1;
  assign cnt_dec   = state_i.counter - 8'd1;

  always_comb begin
    s        = state_i;
    cycle_en = 1'b0;
    dec_req  = 1'b0;
    taken    = 1'b0;
    unique case (mtec_pkg::op_e'(item_i.op))
      mtec_pkg::OP_TICK: begin
        cycle_en = 1'b1;
      end
      mtec_pkg::OP_STOP: begin
        s.mode      = mtec_pkg::MODE_NONE;
        s.stopped   = 1'b1;
        s.toggle_en = 1'b0;
        if (variant_later_i) begin
          s.prescale = '0;
        end
      end
      mtec_pkg::OP_DEC: begin
        if (variant_later_i) begin
          dec_req = 1'b1;
        end else begin
          cycle_en = 1'b1;
        end
      end
      mtec_pkg::OP_PULSE, mtec_pkg::OP_EVENT: begin
        s.mode    = (item_i.op == mtec_pkg::OP_PULSE) ? mtec_pkg::MODE_PULSE
                                                      : mtec_pkg::MODE_EVENT;
        s.watched = item_i.flag_choice;
        s.stopped = 1'b0;
      end
      mtec_pkg::OP_LOAD: begin
        if (variant_later_i) begin
          s.reload = item_i.load_data;
          if (state_i.stopped) begin
            s.counter   = item_i.load_data;
            s.irq       = 1'b0;
            s.toggle_en = 1'b0;
          end
        end else begin
          if (state_i.stopped) begin
            s.reload  = item_i.load_data;
            s.counter = item_i.load_data;
          end
          s.irq  = 1'b0;
          s.mode = mtec_pkg::MODE_NONE;
        end
      end
      mtec_pkg::OP_TIMER: begin
        s.mode    = mtec_pkg::MODE_TIMER;
        s.stopped = 1'b0;
      end
      mtec_pkg::OP_TOG_EN: begin
        s.toggle_en = 1'b1;
      end
      mtec_pkg::OP_BRANCH: begin
        if (state_i.irq) begin
          taken       = 1'b1;
          s.irq       = 1'b0;
          s.toggle_en = 1'b0;
        end
      end
      default: begin
      end
    endcase

    // one machine cycle: edge tracker always follows, mode decides the decrement
    if (cycle_en) begin
      s.prev_flags = item_i.ext_flags;
      if (!state_i.stopped) begin
        case (state_i.mode)
          mtec_pkg::MODE_PULSE: begin
            if (cur_flag) begin
              s.stopped = 1'b1;
            end else begin
              dec_req = 1'b1;
            end
          end
          mtec_pkg::MODE_EVENT: begin
            dec_req = prev_flag && !cur_flag;
          end
          mtec_pkg::MODE_TIMER: begin
            if (pre_nxt == (mtec_pkg::PrescaleW+1)'(mtec_pkg::PRESCALE)) begin
              s.prescale = '0;
              dec_req    = 1'b1;
            end else begin
              s.prescale = pre_nxt[mtec_pkg::PrescaleW-1:0];
            end
          end
          default: begin
            dec_req = 1'b1;
          end
        endcase
      end
    end

    dec_en = dec_req && !state_i.stopped;
    qt     = 1'b0;
    if (dec_en) begin
      if (cnt_dec == 8'd0) begin
        s.counter = state_i.reload;
        s.irq     = 1'b1;
        qt        = state_i.toggle_en;
      end else begin
        s.counter = cnt_dec;
      end
    end
  end

  assign state_o                    = s;
  assign result_o.count_value       = s.counter;
  assign result_o.counter_interrupt = s.irq;
  assign result_o.q_toggle          = qt;
  assign result_o.branch_taken      = taken;

endmodule

// ===== rtl/mode_timer_event_counter_core.sv =====
// ----------------------------------------------------------------------------
// mode_timer_event_counter_core
// 8-bit down counter/timer with reload, pulse, event and timer modes.
// ----------------------------------------------------------------------------
// Takes one transfer per clock while the result side keeps up: each input
// transfer is a machine-cycle tick or a counter command, and gives exactly
// one result transfer. An input register feeds a single pass of next-state
// logic whose outputs land in the result register and the counter state
// together, so a transfer passes the input register and then the result
// register. Timer mode decrements once every 32 ticks.
module mode_timer_event_counter_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // op[3:0], load_data[11:4], ext_flags[15:12], flag_choice[16], zero[23:17]
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // count_value[7:0], counter_interrupt[8], q_toggle[9], branch_taken[10],
  // zero[15:11]
  output logic [15:0] m_axis_tdata
);

  logic              variant_q;
  logic              in_valid_q;
  mtec_pkg::item_t   in_item_q;
  logic              out_valid_q;
  mtec_pkg::result_t out_res_q;
  mtec_pkg::state_t  state_q;
  mtec_pkg::state_t  state_d;
  mtec_pkg::result_t res_d;
  logic              advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      variant_q <= 1'b0;
    end else if (cfg_we_i) begin
      variant_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= mtec_pkg::item_t'(s_axis_tdata[16:0]);
    end
  end

  mtec_step u_step (
    .state_i         (state_q),
    .item_i          (in_item_q),
    .variant_later_i (variant_q),
    .state_o         (state_d),
    .result_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.counter    <= 8'd0;
      state_q.reload     <= 8'd0;
      state_q.mode       <= mtec_pkg::MODE_NONE;
      state_q.stopped    <= 1'b1;
      state_q.prescale   <= '0;
      state_q.toggle_en  <= 1'b0;
      state_q.irq        <= 1'b0;
      state_q.prev_flags <= 4'd0;
      state_q.watched    <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_res_q};

endmodule
